// ===== hdl/xor_framed_serial_receiver_assert.svh =====
// Assertion macros shared by the receiver modules.
// Each module that uses them has i_clk and i_rst_n in scope.
`ifndef XOR_FRAMED_SERIAL_RECEIVER_ASSERT_SVH
`define XOR_FRAMED_SERIAL_RECEIVER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define XFSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define XFSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/xfsr_pkg.sv =====
// ---------------------------------------------------------------------------
// xfsr_pkg
// Shared constants, codes and the result record of the framed serial receiver.
// ---------------------------------------------------------------------------
`default_nettype none

package xfsr_pkg;

    // Frame header bytes
    localparam logic [7:0] HDR_FIRST  = 8'hAA;
    localparam logic [7:0] HDR_SECOND = 8'hBB;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_COMMAND = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS    = 8'd1;
    localparam logic [7:0]  RST_EXPECTED_COMMAND = 8'h20;
    localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd1000;

    // Request types
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

    // Frame result codes
    localparam logic [2:0] RES_OK       = 3'd0;
    localparam logic [2:0] RES_CHECKSUM = 3'd1;
    localparam logic [2:0] RES_COMMAND  = 3'd2;
    localparam logic [2:0] RES_TIMEOUT  = 3'd3;
    localparam logic [2:0] RES_SHORT    = 3'd4;

    // One result transaction
    typedef struct packed {
        logic       out_kind;
        logic [7:0] data_byte;
        logic [7:0] status_byte;
        logic [7:0] payload_count;
        logic [2:0] frame_result;
        logic       last;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/xor_framed_serial_receiver.sv =====
// ---------------------------------------------------------------------------
// Framed serial receiver with XOR checksum.
// Request channel (i_valid/o_ready): each transaction is one received byte
//   (i_req_type 0, i_rx_byte) or one time tick (i_req_type 1).
// Result channel (o_valid/i_ready): payload bytes as they arrive, and one
//   closing report per frame (o_last 1) with status, payload count and code.
// Config channel (i_cfg_valid/o_cfg_ready): index 0 sets the expected
//   command, index 1 the timeout in ticks; it is always ready.
// Throughput: one request per cycle while o_ready is high. The frame parser
//   updates its state in the accepting cycle; the result reaches o_valid through the registered output stage.
// Stall: a two-entry output stage (output register plus skid) absorbs one
//   extra result; o_ready drops only when both entries hold data, and comes
//   from a register.
// Reset (i_rst_n low, synchronous): parser back to header hunt, timer
//   disarmed, output stage empty, registers to 0x20 and 1000 ticks.
// ---------------------------------------------------------------------------
`default_nettype none

module xor_framed_serial_receiver (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire         i_req_type,
    input  wire [7:0]   i_rx_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic        o_out_kind,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_status_byte,
    output logic [7:0]  o_payload_count,
    output logic [2:0]  o_frame_result,
    output logic        o_last,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire [xfsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [15:0]  i_cfg_data
);

    logic [7:0]        r_expected_command;
    logic [15:0]       r_timeout_ticks;
    logic              res_valid;
    xfsr_pkg::t_result res;
    xfsr_pkg::t_result out_res;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; writes to unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_command <= xfsr_pkg::RST_EXPECTED_COMMAND;
            r_timeout_ticks    <= xfsr_pkg::RST_TIMEOUT_TICKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                xfsr_pkg::CFG_EXPECTED_COMMAND: r_expected_command <= i_cfg_data[7:0];
                xfsr_pkg::CFG_TIMEOUT_TICKS:    r_timeout_ticks    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    xfsr_frame_fsm u_fsm (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req_valid        (i_valid),
        .i_req_ready        (o_ready),
        .i_req_type         (i_req_type),
        .i_rx_byte          (i_rx_byte),
        .i_expected_command (r_expected_command),
        .i_timeout_ticks    (r_timeout_ticks),
        .o_res_valid        (res_valid),
        .o_res              (res)
    );

    xfsr_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .o_space (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_res)
    );

    // Unpack the result transaction onto the ports
    assign o_out_kind      = out_res.out_kind;
    assign o_data_byte     = out_res.data_byte;
    assign o_status_byte   = out_res.status_byte;
    assign o_payload_count = out_res.payload_count;
    assign o_frame_result  = out_res.frame_result;
    assign o_last          = out_res.last;

endmodule

`default_nettype wire

// ===== hdl/xfsr_frame_fsm.sv =====
// ---------------------------------------------------------------------------
// xfsr_frame_fsm
// Frame parser: header hunt, length, status, payload and checksum phases,
// plus the inter-byte timeout. One request is consumed per cycle while i_req_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none
`include "xor_framed_serial_receiver_assert.svh"

module xfsr_frame_fsm (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    input  wire                  i_req_ready,
    input  wire                  i_req_type,
    input  wire [7:0]            i_rx_byte,
    input  wire [7:0]            i_expected_command,
    input  wire [15:0]           i_timeout_ticks,
    output logic                 o_res_valid,
    output xfsr_pkg::t_result    o_res
);

    // Phase codes
    localparam logic [2:0] PH_HUNT    = 3'd0;
    localparam logic [2:0] PH_LENGTH  = 3'd1;
    localparam logic [2:0] PH_STATUS  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK   = 3'd4;

    logic [2:0]  r_phase,  n_phase;
    logic        r_saw_aa, n_saw_aa;
    logic [7:0]  r_left,   n_left;
    logic [7:0]  r_count,  n_count;
    logic [7:0]  r_xor,    n_xor;
    logic [7:0]  r_status, n_status;
    logic [15:0] r_idle,   n_idle;
    logic        r_armed,  n_armed;

    logic        take;
    logic [15:0] limit;
    logic [15:0] idle_inc;

    assign take     = i_req_valid & i_req_ready;
    assign limit    = (i_timeout_ticks == 16'd0) ? 16'd1 : i_timeout_ticks;
    assign idle_inc = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;

    // Compute next state and the result of the current transaction
    always_comb begin
        n_phase     = r_phase;
        n_saw_aa    = r_saw_aa;
        n_left      = r_left;
        n_count     = r_count;
        n_xor       = r_xor;
        n_status    = r_status;
        n_idle      = r_idle;
        n_armed     = r_armed;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (take) begin
            if (i_req_type == xfsr_pkg::REQ_TICK) begin
                // Count ticks only while armed; close the frame on timeout
                if (r_armed) begin
                    n_idle = idle_inc;
                    if (idle_inc >= limit) begin
                        o_res_valid         = 1'b1;
                        o_res.out_kind      = xfsr_pkg::KIND_REPORT;
                        o_res.status_byte   = r_status;
                        o_res.payload_count = r_count;
                        o_res.frame_result  = xfsr_pkg::RES_TIMEOUT;
                        o_res.last          = 1'b1;
                    end
                end
            end else begin
                n_armed = 1'b1;
                n_idle  = 16'd0;
                case (r_phase)
                    PH_HUNT: begin
                        if (r_saw_aa && i_rx_byte == xfsr_pkg::HDR_SECOND) begin
                            n_phase  = PH_LENGTH;
                            n_count  = 8'd0;
                            n_status = 8'd0;
                        end
                        n_saw_aa = (i_rx_byte == xfsr_pkg::HDR_FIRST);
                    end
                    PH_LENGTH: begin
                        n_xor  = i_rx_byte;
                        n_left = i_rx_byte - 8'd2;
                        if (i_rx_byte < 8'd2) begin
                            o_res_valid        = 1'b1;
                            o_res.out_kind     = xfsr_pkg::KIND_REPORT;
                            o_res.frame_result = xfsr_pkg::RES_SHORT;
                            o_res.last         = 1'b1;
                        end else begin
                            n_phase = PH_STATUS;
                        end
                    end
                    PH_STATUS: begin
                        n_status = i_rx_byte;
                        n_xor    = r_xor ^ i_rx_byte;
                        n_phase  = (r_left == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                    end
                    PH_PAYLOAD: begin
                        n_xor   = r_xor ^ i_rx_byte;
                        n_left  = r_left - 8'd1;
                        n_count = r_count + 8'd1;
                        if (r_left == 8'd1) begin
                            n_phase = PH_CHECK;
                        end
                        o_res_valid     = 1'b1;
                        o_res.out_kind  = xfsr_pkg::KIND_PAYLOAD;
                        o_res.data_byte = i_rx_byte;
                    end
                    default: begin
                        // Checksum byte: checksum error wins over command error
                        o_res_valid         = 1'b1;
                        o_res.out_kind      = xfsr_pkg::KIND_REPORT;
                        o_res.status_byte   = r_status;
                        o_res.payload_count = r_count;
                        o_res.last          = 1'b1;
                        if (i_rx_byte != r_xor) begin
                            o_res.frame_result = xfsr_pkg::RES_CHECKSUM;
                        end else if (r_status != i_expected_command) begin
                            o_res.frame_result = xfsr_pkg::RES_COMMAND;
                        end else begin
                            o_res.frame_result = xfsr_pkg::RES_OK;
                        end
                    end
                endcase
            end

            // Any closing report returns to the header hunt
            if (o_res_valid && o_res.last) begin
                n_phase  = PH_HUNT;
                n_saw_aa = 1'b0;
                n_armed  = 1'b0;
                n_idle   = 16'd0;
                n_status = 8'd0;
                n_count  = 8'd0;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HUNT;
            r_saw_aa <= 1'b0;
            r_armed  <= 1'b0;
            r_idle   <= 16'd0;
            r_status <= 8'd0;
            r_count  <= 8'd0;
        end else begin
            r_phase  <= n_phase;
            r_saw_aa <= n_saw_aa;
            r_armed  <= n_armed;
            r_idle   <= n_idle;
            r_status <= n_status;
            r_count  <= n_count;
        end
    end

    // Frame datapath
    always_ff @(posedge i_clk) begin
        r_left <= n_left;
        r_xor  <= n_xor;
    end

    `XFSR_ASSERT_NOW(a_idle_clear_when_disarmed, !r_armed, r_idle == 16'd0,
        "idle tick count nonzero while timer disarmed")
    `XFSR_ASSERT_NEXT(a_payload_keeps_frame,
        o_res_valid && o_res.out_kind == xfsr_pkg::KIND_PAYLOAD,
        r_phase == PH_PAYLOAD || r_phase == PH_CHECK,
        "payload transaction did not stay inside the frame")
    `XFSR_ASSERT_NEXT(a_report_returns_to_hunt, o_res_valid && o_res.last,
        r_phase == PH_HUNT && !r_armed && !r_saw_aa,
        "closing report did not return to header hunt")

endmodule

`default_nettype wire

// ===== hdl/xfsr_out_skid.sv =====
// ---------------------------------------------------------------------------
// xfsr_out_skid
// Registered output stage with one skid entry. Upstream ready comes from a
// register, so no combinational path runs from downstream ready upstream.
// ---------------------------------------------------------------------------
`default_nettype none
`include "xor_framed_serial_receiver_assert.svh"

module xfsr_out_skid (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire xfsr_pkg::t_result i_data,
    output logic                 o_space,
    output logic                 o_valid,
    input  wire                  i_ready,
    output xfsr_pkg::t_result    o_data
);

    logic              r_main_v;
    logic              r_skid_v;
    xfsr_pkg::t_result r_main;
    xfsr_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_main_v & i_ready;
    assign o_space = ~r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    // Advance the output register, or park an incoming transaction in the skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_main_v || pop) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (!r_main_v || pop) begin
            r_main <= r_skid_v ? r_skid : i_data;
        end
        if (r_main_v && !pop && i_push) begin
            r_skid <= i_data;
        end
    end

    `XFSR_ASSERT_NOW(a_skid_implies_main, r_skid_v, r_main_v,
        "skid entry held without an output entry")
    `XFSR_ASSERT_NEXT(a_stall_fills_skid, r_main_v && !i_ready && i_push,
        r_skid_v, "stalled transaction was not parked in skid")
    `XFSR_ASSERT_NEXT(a_skid_drains, r_skid_v && i_ready, r_main_v && !r_skid_v,
        "skid entry did not move to the output")

endmodule

`default_nettype wire
